// ===== hw/rtl/b64e_pkg.sv =====
// b64e_pkg: shared types, constants and the alphabet lookup for the base64 encoder
// no dependencies; compiled first
package b64e_pkg;

  localparam logic [7:0] PadChar  = 8'h3D;
  localparam logic [5:0] SixMask  = 6'h3F;
  localparam logic [7:0] PlusChar = 8'h2B;
  localparam logic [7:0] SlashChar = 8'h2F;

  // number of '=' characters that close a group
  localparam logic [1:0] PadNone = 2'd0;
  localparam logic [1:0] PadOne  = 2'd1;
  localparam logic [1:0] PadTwo  = 2'd2;

  // bytes held in the front end
  localparam logic [1:0] HeldNone = 2'd0;
  localparam logic [1:0] HeldOne  = 2'd1;
  localparam logic [1:0] HeldTwo  = 2'd2;

  // character positions within a group
  localparam logic [1:0] CharFirst  = 2'd0;
  localparam logic [1:0] CharSecond = 2'd1;
  localparam logic [1:0] CharThird  = 2'd2;
  localparam logic [1:0] CharFourth = 2'd3;

  // one complete group handed from front to back
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  pad;
    logic        last;
  } group_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] idx);
    logic [7:0] ch;
    if (idx < 6'd26) begin
      ch = 8'(8'd65 + {2'b00, idx});
    end else if (idx < 6'd52) begin
      ch = 8'(8'd71 + {2'b00, idx});
    end else if (idx < 6'd62) begin
      ch = 8'({2'b00, idx} - 8'd4);
    end else if (idx == 6'd62) begin
      ch = PlusChar;
    end else begin
      ch = SlashChar;
    end
    return ch;
  endfunction

endpackage

// ===== hw/rtl/b64e_if.sv =====
// b64e_if: valid/ready stream interfaces for the byte and character channels
// no dependencies
interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ===== hw/rtl/b64e_front.sv =====
// b64e_front: collects bytes into groups of three and pushes finished groups
// depends on b64e_pkg and b64e_byte_if
module b64e_front
  import b64e_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  b64e_byte_if.sink in_stream,
  output logic   push_valid,
  output group_t push_data,
  input  logic   push_ready
);

  logic [1:0] count_r, count_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] second_r, second_nxt;
  logic       take;

  assign in_stream.ready = push_ready;
  assign take = in_stream.valid && push_ready;

  always_comb begin
    count_nxt  = count_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    push_valid = 1'b0;
    push_data  = '{bits: 24'd0, pad: PadNone, last: 1'b0};
    unique case (count_r)
      HeldNone: begin
        if (in_stream.last_byte) begin
          push_valid = take;
          push_data  = '{bits: {in_stream.data_byte, 16'd0}, pad: PadTwo, last: 1'b1};
          count_nxt  = take ? HeldNone : count_r;
        end else if (take) begin
          first_nxt = in_stream.data_byte;
          count_nxt = HeldOne;
        end
      end
      HeldOne: begin
        if (in_stream.last_byte) begin
          push_valid = take;
          push_data  = '{bits: {first_r, in_stream.data_byte, 8'd0}, pad: PadOne,
                         last: 1'b1};
          count_nxt  = take ? HeldNone : count_r;
        end else if (take) begin
          second_nxt = in_stream.data_byte;
          count_nxt  = HeldTwo;
        end
      end
      default: begin
        // two bytes held; a count of three cannot arise, it acts the same
        push_valid = take;
        push_data  = '{bits: {first_r, second_r, in_stream.data_byte}, pad: PadNone,
                       last: in_stream.last_byte};
        count_nxt  = take ? HeldNone : count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= HeldNone;
    end else begin
      count_r <= count_nxt;
    end
    first_r  <= first_nxt;
    second_r <= second_nxt;
  end

endmodule

// ===== hw/rtl/b64e_fifo.sv =====
// b64e_fifo: short queue of finished groups between front and back
// depends on b64e_pkg
module b64e_fifo
  import b64e_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  input  group_t push_data,
  output logic   push_ready,
  output logic   pop_valid,
  output group_t pop_data,
  input  logic   pop_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  group_t        slot_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          do_push, do_pop;

  assign push_ready = (fill_r != Full);
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = slot_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_nxt   = wr_r;
    rd_nxt   = rd_r;
    fill_nxt = fill_r;
    if (do_push) begin
      wr_nxt = (wr_r == LastSlot) ? '0 : AW'(wr_r + 1'b1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == LastSlot) ? '0 : AW'(rd_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = CW'(fill_r + 1'b1);
    end else if (do_pop && !do_push) begin
      fill_nxt = CW'(fill_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
      fill_r <= fill_nxt;
    end
    if (do_push) begin
      slot_r[wr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/b64e_back.sv =====
// b64e_back: turns a queued group into four characters, one per cycle while not stalled
// depends on b64e_pkg and b64e_char_if
module b64e_back
  import b64e_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   pop_valid,
  input  group_t pop_data,
  output logic   pop_ready,
  b64e_char_if.source out_stream
);

  group_t     grp_r, grp_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;
  logic       adv;
  logic [5:0] sextet;
  logic       is_pad;

  assign adv       = busy_r && (!out_valid_r || out_stream.ready);
  // take the next group while the fourth character goes out, so no bubble
  assign pop_ready = !busy_r || (adv && idx_r == CharFourth);

  always_comb begin
    unique case (idx_r)
      CharFirst:  sextet = grp_r.bits[23:18];
      CharSecond: sextet = grp_r.bits[17:12];
      CharThird:  sextet = grp_r.bits[11:6];
      default:    sextet = grp_r.bits[5:0];
    endcase
    is_pad = ((idx_r == CharFourth) && (grp_r.pad != PadNone)) ||
             ((idx_r == CharThird) && (grp_r.pad == PadTwo));
  end

  always_comb begin
    grp_nxt       = grp_r;
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = is_pad ? PadChar : sextet_char(sextet & SixMask);
      out_last_nxt  = grp_r.last && (idx_r == CharFourth);
      idx_nxt       = 2'(idx_r + 1'b1);
      if (idx_r == CharFourth) begin
        busy_nxt = 1'b0;
      end
    end else if (out_stream.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop_valid && pop_ready) begin
      grp_nxt  = pop_data;
      busy_nxt = 1'b1;
      idx_nxt  = CharFirst;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= CharFirst;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    grp_r      <= grp_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_stream.valid     = out_valid_r;
  assign out_stream.out_char  = out_char_r;
  assign out_stream.last_char = out_last_r;

endmodule

// ===== hw/rtl/base64_stream_encoder_unit.sv =====
// base64_stream_encoder_unit: top level of the streaming base64 encoder
// depends on b64e_pkg, b64e_if, b64e_front, b64e_fifo and b64e_back
//
//   channel     dir  payload                 transfer
//   in_stream   in   data_byte, last_byte    valid && ready
//   out_stream  out  out_char, last_char     valid && ready
//
// a byte is taken every cycle while the group queue has room
// the character generator emits one character per cycle while the output is
// not stalled, four per group; a closed group is registered in the queue slot
// and the group register, its first character then in the output register
// synchronous active-low reset clears counts, queue and output valid
// a stalled output fills the queue, after which in_stream.ready drops
module base64_stream_encoder_unit
  import b64e_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  b64e_byte_if.sink   in_stream,
  b64e_char_if.source out_stream
);

  logic   push_valid, push_ready;
  group_t push_data;
  logic   pop_valid, pop_ready;
  group_t pop_data;

  b64e_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_stream),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  b64e_fifo #(.DEPTH(DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready),
    .out_stream (out_stream)
  );

endmodule

// ===== hw/rtl/b64e_checker.sv =====
// b64e_checker: port-level checks on the encoder output channel
// depends on b64e_pkg; bound to base64_stream_encoder_unit
module b64e_checker
  import b64e_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       last_char
);

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_char) && $stable(last_char))
    else $error("output payload changed while stalled");

  // a pad in third place is always followed by a second pad that closes the group
  a_pad_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char == PadChar && !last_char |=> out_valid && out_char == PadChar)
    else $error("single pad not followed by closing pad");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char >= 8'h41 && out_char <= 8'h5A) ||
                  (out_char >= 8'h61 && out_char <= 8'h7A) ||
                  (out_char >= 8'h30 && out_char <= 8'h39) ||
                  out_char == PlusChar || out_char == SlashChar || out_char == PadChar)
    else $error("character outside the base64 set");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind base64_stream_encoder_unit b64e_checker u_b64e_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_stream.valid),
  .out_ready (out_stream.ready),
  .out_char  (out_stream.out_char),
  .last_char (out_stream.last_char)
);

// ===== verif/tb_base64_stream_encoder_unit.sv =====
// tb_base64_stream_encoder_unit: self-checking bench for the streaming base64 encoder
// depends on b64e_pkg, b64e_if and base64_stream_encoder_unit; messages go in as
// bytes, a local encoder model predicts the characters, the monitor compares them
module tb_base64_stream_encoder_unit;
  import b64e_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomBytes = 290;
  localparam logic [0:63][7:0] B64Symbols =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    logic [7:0]  data;
    logic        last;
    int unsigned gap;
    bit          drain;
  } msg_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } b64_char_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic       src_valid = 1'b0;
  logic [7:0] src_data  = 8'h00;
  logic       src_last  = 1'b0;
  logic       snk_ready = 1'b0;

  b64e_byte_if byte_ch ();
  b64e_char_if char_ch ();

  assign byte_ch.valid     = src_valid;
  assign byte_ch.data_byte = src_data;
  assign byte_ch.last_byte = src_last;
  assign char_ch.ready     = snk_ready;

  base64_stream_encoder_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (byte_ch),
    .out_stream(char_ch)
  );

  always #4 clk = ~clk;

  msg_byte_t   pending_bytes[$];
  b64_char_t   expected_chars[$];
  int unsigned fault_count = 0;
  bit          sender_eager = 1'b0;

  // encoder model state
  logic [7:0] held_first  = 8'h00;
  logic [7:0] held_second = 8'h00;
  logic [1:0] held_count  = HeldNone;

  task automatic push_quad(input logic [23:0] bits, input int unsigned real_chars,
                           input logic last);
    b64_char_t   c;
    logic [5:0]  sextet;
    for (int k = 0; k < 4; k++) begin
      sextet = 6'(bits >> (18 - 6 * k));
      c.ch   = (k < real_chars) ? B64Symbols[sextet] : PadChar;
      c.last = last && (k == 3);
      expected_chars.push_back(c);
    end
  endtask

  task automatic encode_byte(input logic [7:0] data, input logic last);
    case (held_count)
      HeldOne: begin
        if (!last) begin
          held_second = data;
          held_count  = HeldTwo;
        end else begin
          push_quad({held_first, data, 8'h00}, 3, 1'b1);
          held_count = HeldNone;
        end
      end
      HeldTwo: begin
        push_quad({held_first, held_second, data}, 4, last);
        held_count = HeldNone;
      end
      default: begin
        if (!last) begin
          held_first = data;
          held_count = HeldOne;
        end else begin
          push_quad({data, 16'h0000}, 2, 1'b1);
          held_count = HeldNone;
        end
      end
    endcase
  endtask

  task automatic queue_byte(input logic [7:0] data, input logic last, input bit drain);
    msg_byte_t b;
    b.data  = data;
    b.last  = last;
    b.gap   = sender_eager ? 0 : $urandom_range(0, 8);
    b.drain = drain;
    pending_bytes.push_back(b);
  endtask

  // driver
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    bit busy;
    if (!rst_n) begin
      src_valid   <= 1'b0;
      idle_cycles = 0;
    end else begin
      busy = src_valid;
      if (src_valid && byte_ch.ready) begin
        encode_byte(src_data, src_last);
        busy = 1'b0;
      end
      if (!busy && pending_bytes.size() != 0) begin
        if (pending_bytes[0].drain && expected_chars.size() != 0) begin
          // hold off until the encoder has emptied
        end else if (idle_cycles < pending_bytes[0].gap) begin
          idle_cycles++;
        end else begin
          msg_byte_t b;
          b = pending_bytes.pop_front();
          src_data    <= b.data;
          src_last    <= b.last;
          busy        = 1'b1;
          idle_cycles = 0;
        end
      end
      src_valid <= busy;
    end
  end

  // monitor
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  bit          sink_eager = 1'b0;

  always @(posedge clk) begin
    b64_char_t want;
    if (!rst_n) begin
      snk_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      cycle_count++;
      if (cycle_count % 200 == 0) sink_eager = ($urandom_range(0, 3) == 0);
      if (char_ch.valid && char_ch.ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected transfer char %02h last %0b", $time,
                   char_ch.out_char, char_ch.last_char);
          fault_count++;
        end else begin
          want = expected_chars.pop_front();
          if (char_ch.out_char !== want.ch) begin
            $display("%0t: out_char expected %02h got %02h", $time, want.ch,
                     char_ch.out_char);
            fault_count++;
          end
          if (char_ch.last_char !== want.last) begin
            $display("%0t: last_char expected %0b got %0b", $time, want.last,
                     char_ch.last_char);
            fault_count++;
          end
        end
        stall_left = sink_eager ? 0 : $urandom_range(0, 8);
      end
      if (stall_left > 0) begin
        stall_left--;
        snk_ready <= 1'b0;
      end else begin
        snk_ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned queued;
    int unsigned msg_len;
    logic [7:0]  d;

    // last byte alone, as second and as third of a group
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b1, 1'b0);
    queue_byte(8'hFB, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'hBF, 1'b1, 1'b0);
    // full groups followed by a short closing group, then a message that closes on a full group
    sender_eager = 1'b1;
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h4D, 1'b1, 1'b0);
    sender_eager = 1'b0;
    queue_byte(8'h80, 1'b0, 1'b0);
    queue_byte(8'h01, 1'b0, 1'b0);
    queue_byte(8'h7F, 1'b0, 1'b0);
    queue_byte(8'hA5, 1'b0, 1'b0);
    queue_byte(8'h5A, 1'b1, 1'b0);
    queue_byte(8'h4D, 1'b0, 1'b1);
    queue_byte(8'h61, 1'b0, 1'b0);
    queue_byte(8'h6E, 1'b1, 1'b0);

    queued = 0;
    while (queued < RandomBytes) begin
      if ($urandom_range(0, 3) == 0) sender_eager = ~sender_eager;
      msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 9);
      for (int i = 0; i < msg_len; i++) begin
        case ($urandom_range(0, 9))
          0:       d = 8'h00;
          1:       d = 8'hFF;
          default: d = 8'($urandom);
        endcase
        // now and then wait for the encoder to empty before a new message
        queue_byte(d, i == msg_len - 1, i == 0 && $urandom_range(0, 15) == 0);
      end
      queued += msg_len;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || src_valid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);

    if (fault_count == 0 && expected_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_if.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_fifo.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_stream_encoder_unit.sv
hw/rtl/b64e_checker.sv
verif/tb_base64_stream_encoder_unit.sv
